/* rtl/akr_pkg.sv */
// Shared constants, types and helpers of the arrow-key escape recogniser.
package akr_pkg;

   // Bytes of the cursor sequences ESC '[' 'A'..'D'.
   localparam logic [7:0] ESC_BYTE     = 8'h1B;
   localparam logic [7:0] BRACKET_BYTE = 8'h5B;
   localparam logic [7:0] FINAL_BASE   = 8'h41;

   // Request action codes.
   localparam logic ACT_CHAR = 1'b0;
   localparam logic ACT_POP  = 1'b1;

   // Key codes reported on the result channel.
   localparam logic [2:0] KEY_UP    = 3'd0;
   localparam logic [2:0] KEY_DOWN  = 3'd1;
   localparam logic [2:0] KEY_RIGHT = 3'd2;
   localparam logic [2:0] KEY_LEFT  = 3'd3;
   localparam logic [2:0] KEY_NONE  = 3'd4;

   // Character lengths with a meaning of their own.
   localparam logic [2:0] LEN_TIMEOUT = 3'd0;
   localparam logic [2:0] LEN_SINGLE  = 3'd1;

   // One stored character: length above its bytes.
   typedef struct packed {
      logic [2:0]  len;
      logic [31:0] bytes;
   } entry_type;

   // Characters that one event pushes: some pending bytes, then perhaps the current one.
   typedef struct packed {
      logic [1:0] n_pend;
      logic       with_cur;
      entry_type  cur;
   } push_req_type;

   // Outcome of a character event for the recognition attempt.
   typedef struct packed {
      logic       decided;
      logic [2:0] key;
   } verdict_type;

   // Byte that candidate cand expects at position pos of its sequence.
   function automatic logic [7:0] expected_byte(input logic [1:0] cand, input logic [1:0] pos);
      logic [7:0] result;
      case (pos)
         2'd0:    result = ESC_BYTE;
         2'd1:    result = BRACKET_BYTE;
         default: result = FINAL_BASE + {6'd0, cand};
      endcase
      return result;
   endfunction

endpackage

/* rtl/arrow_key_escape_recognizer.sv */
// Top level of the arrow-key escape recogniser with its character FIFO.
//
//   Channel | Prefix | Direction | Transaction
//   --------+--------+-----------+-------------------------------------------------
//   request | req_   | in        | character event (action 0) or pop (action 1)
//   result  | rsp_   | out       | one result per request: verdict, popped char, fill
//
// A request is accepted in any cycle in which the FIFO write sequencer is idle and the
// result side can take another transaction; its result passes through stage one and
// then the output register to rsp_. The FIFO memory has one write port: a transaction
// that pushes more than one character (up to four) keeps req_ready low while the rest
// of its entries are written, so the rate is one request per cycle only without such
// pushes and while the result side keeps up. Reset is synchronous and active high; it
// empties the FIFO and restarts recognition, with no clearing pass over the memory.
// A stalled result holds in the output register while one more request can still be taken.
module arrow_key_escape_recognizer
   import akr_pkg::*;
#(
   parameter int FIFO_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [31:0] req_char_bytes,
   input  logic [2:0]  req_char_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_decided,
   output logic [2:0]  rsp_key_code,
   output logic [31:0] rsp_popped_bytes,
   output logic [2:0]  rsp_popped_length,
   output logic        rsp_overflow,
   output logic [6:0]  rsp_fill_level
);

   push_req_type    push_req;
   verdict_type     verdict;
   logic [2:0][7:0] pend_bytes;
   entry_type       rd_data;
   logic            accept, wr_busy, fifo_overflow, pop_hit, out_free, s1_move;
   logic [6:0]      fill_level;

   // Stage one holds the verdict while the memory read of a pop completes.
   logic            s1_valid_ff, s1_valid_in;
   logic            s1_decided_ff;
   logic [2:0]      s1_key_ff;
   logic            s1_ovf_ff;
   logic            s1_hit_ff;
   logic [6:0]      s1_fill_ff;

   // Output register.
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_decided_ff;
   logic [2:0]      rsp_key_ff;
   logic [31:0]     rsp_bytes_ff;
   logic [2:0]      rsp_length_ff;
   logic            rsp_ovf_ff;
   logic [6:0]      rsp_fill_ff;

   akr_recog u_recog (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .action      (req_action),
      .char_bytes  (req_char_bytes),
      .char_length (req_char_length),
      .push_req    (push_req),
      .verdict     (verdict),
      .pend_bytes  (pend_bytes)
   );

   akr_fifo #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .action     (req_action),
      .push_req   (push_req),
      .pend_bytes (pend_bytes),
      .wr_busy    (wr_busy),
      .overflow   (fifo_overflow),
      .pop_hit    (pop_hit),
      .fill_level (fill_level),
      .rd_data    (rd_data)
   );

   // The output register frees up when empty or when its transaction is being taken.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_ready = !wr_busy && (!s1_valid_ff || out_free);
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (accept)       s1_valid_in = 1'b1;
      else if (s1_move) s1_valid_in = 1'b0;
      else              s1_valid_in = s1_valid_ff;

      if (s1_move)        rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else                rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_decided_ff <= verdict.decided;
         s1_key_ff     <= verdict.key;
         s1_ovf_ff     <= fifo_overflow;
         s1_hit_ff     <= pop_hit;
         s1_fill_ff    <= fill_level;
      end
      if (s1_move) begin
         rsp_decided_ff <= s1_decided_ff;
         rsp_key_ff     <= s1_key_ff;
         rsp_ovf_ff     <= s1_ovf_ff;
         rsp_fill_ff    <= s1_fill_ff;
         rsp_bytes_ff   <= s1_hit_ff ? rd_data.bytes : 32'd0;
         rsp_length_ff  <= s1_hit_ff ? rd_data.len : LEN_TIMEOUT;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_decided       = rsp_decided_ff;
   assign rsp_key_code      = rsp_key_ff;
   assign rsp_popped_bytes  = rsp_bytes_ff;
   assign rsp_popped_length = rsp_length_ff;
   assign rsp_overflow      = rsp_ovf_ff;
   assign rsp_fill_level    = rsp_fill_ff;

   // A popped character never comes with a verdict, since pops leave recognition alone.
   ap_pop_has_no_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_popped_length != LEN_TIMEOUT |-> !rsp_decided && rsp_key_code == KEY_NONE)
      else $error("popped character reported together with a verdict");

   // Only an event that ends an attempt can push, so only such an event can overflow.
   ap_overflow_is_decided: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_decided)
      else $error("overflow reported without an ended attempt");

   // An accepted pop always lands in stage one without a verdict.
   ap_pop_into_stage: assert property (@(posedge clock) disable iff (reset)
      accept && req_action == ACT_POP |=> s1_valid_ff && !s1_decided_ff)
      else $error("accepted pop did not enter the read stage");

endmodule

/* rtl/akr_recog.sv */
// Sequence recogniser: candidate mask, pending bytes and the verdict of each event.
module akr_recog
   import akr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              action,
   input  logic [31:0]       char_bytes,
   input  logic [2:0]        char_length,
   output push_req_type      push_req,
   output verdict_type       verdict,
   output logic [2:0][7:0]   pend_bytes
);

   logic [3:0]      mask_ff, mask_in;
   logic [1:0]      count_ff, count_in;
   logic [2:0][7:0] pend_ff, pend_in;

   always_comb begin
      logic [7:0] cur_byte;
      logic [3:0] new_mask;
      logic       has_char;
      cur_byte = char_bytes[7:0];
      has_char = (char_length != LEN_TIMEOUT);
      mask_in  = mask_ff;
      count_in = count_ff;
      pend_in  = pend_ff;
      push_req = '0;
      verdict  = '{decided: 1'b0, key: KEY_NONE};
      new_mask = '0;
      for (int c = 0; c < 4; c++) begin
         if (count_ff != 2'd3 && cur_byte != 8'd0 && mask_ff[c] &&
             expected_byte(2'(c), count_ff) == cur_byte) begin
            new_mask[c] = 1'b1;
         end
      end
      if (action == ACT_CHAR) begin
         if (char_length != LEN_SINGLE) begin
            // A timeout or a multi-byte character closes the attempt.
            verdict.decided   = 1'b1;
            push_req.with_cur = has_char;
            push_req.cur      = '{len: char_length, bytes: char_bytes};
            if (count_ff == 2'd3 && mask_ff != 4'd0) begin
               if (mask_ff[0])      verdict.key = KEY_UP;
               else if (mask_ff[1]) verdict.key = KEY_DOWN;
               else if (mask_ff[2]) verdict.key = KEY_RIGHT;
               else                 verdict.key = KEY_LEFT;
            end else begin
               push_req.n_pend = count_ff;
            end
            mask_in  = 4'hF;
            count_in = 2'd0;
         end else if (new_mask == 4'd0) begin
            // Mismatch: everything pending goes out as text with this byte.
            verdict.decided   = 1'b1;
            push_req.n_pend   = count_ff;
            push_req.with_cur = 1'b1;
            push_req.cur      = '{len: LEN_SINGLE, bytes: {24'd0, cur_byte}};
            mask_in           = 4'hF;
            count_in          = 2'd0;
         end else begin
            mask_in = new_mask;
            for (int i = 0; i < 3; i++) begin
               if (count_ff == 2'(i)) pend_in[i] = cur_byte;
            end
            count_in = count_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= 4'hF;
         count_ff <= 2'd0;
      end else if (accept) begin
         mask_ff  <= mask_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) pend_ff <= pend_in;
   end

   assign pend_bytes = pend_ff;

endmodule

/* rtl/akr_fifo.sv */
// Character FIFO: storage memory, pointers, fill count and the push write sequencer.
module akr_fifo
   import akr_pkg::*;
#(
   parameter int FIFO_DEPTH = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic            action,
   input  push_req_type    push_req,
   input  logic [2:0][7:0] pend_bytes,
   output logic            wr_busy,
   output logic            overflow,
   output logic            pop_hit,
   output logic [6:0]      fill_level,
   output entry_type       rd_data
);

   localparam int AW = $clog2(FIFO_DEPTH);
   localparam int FW = $clog2(FIFO_DEPTH + 1);

   entry_type       mem [FIFO_DEPTH];
   entry_type       rd_data_ff;
   logic [AW-1:0]   head_ff, head_in;
   logic [AW-1:0]   tail_ff, tail_in;
   logic [FW-1:0]   fill_ff, fill_in;
   logic [1:0]      wq_left_ff, wq_left_in;
   logic [1:0]      wq_idx_ff, wq_idx_in;
   logic [1:0]      wq_npend_ff;
   entry_type       wq_cur_ff;
   logic [2:0]      push_n;
   logic            push_go, pop_go, fits, wr_en;
   logic [AW-1:0]   wr_addr;
   entry_type       wr_data;

   function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] ptr);
      return (ptr == AW'(FIFO_DEPTH - 1)) ? '0 : ptr + AW'(1);
   endfunction

   // Entry idx of a push: pending bytes first, then the current character.
   function automatic entry_type pick(input logic [1:0] idx, input logic [1:0] np,
                                      input logic [2:0][7:0] pb, input entry_type cur);
      entry_type result;
      if (idx < np) result = '{len: LEN_SINGLE, bytes: {24'd0, pb[idx]}};
      else          result = cur;
      return result;
   endfunction

   always_comb begin
      logic [FW:0] room_sum;
      push_n   = {1'b0, push_req.n_pend} + {2'd0, push_req.with_cur};
      room_sum = (FW+1)'(fill_ff) + (FW+1)'(push_n);
      fits     = (room_sum <= (FW+1)'(FIFO_DEPTH));
      push_go  = accept && (action == ACT_CHAR) && fits && (push_n != 3'd0);
      overflow = accept && (action == ACT_CHAR) && !fits;
      pop_go   = accept && (action == ACT_POP) && (fill_ff != '0);

      wr_en      = 1'b0;
      wr_addr    = tail_ff;
      wr_data    = push_req.cur;
      wq_left_in = wq_left_ff;
      wq_idx_in  = wq_idx_ff;
      if (push_go) begin
         // The first entry is written at the accepting edge itself.
         wr_en      = 1'b1;
         wr_data    = pick(2'd0, push_req.n_pend, pend_bytes, push_req.cur);
         wq_left_in = 2'(push_n - 3'd1);
         wq_idx_in  = 2'd1;
      end else if (wq_left_ff != 2'd0) begin
         wr_en      = 1'b1;
         wr_data    = pick(wq_idx_ff, wq_npend_ff, pend_bytes, wq_cur_ff);
         wq_left_in = wq_left_ff - 2'd1;
         wq_idx_in  = wq_idx_ff + 2'd1;
      end

      tail_in = wr_en ? next_ptr(tail_ff) : tail_ff;
      head_in = pop_go ? next_ptr(head_ff) : head_ff;
      if (push_go)     fill_in = fill_ff + FW'(push_n);
      else if (pop_go) fill_in = fill_ff - FW'(1);
      else             fill_in = fill_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         tail_ff    <= '0;
         fill_ff    <= '0;
         wq_left_ff <= 2'd0;
         wq_idx_ff  <= 2'd0;
      end else begin
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         fill_ff    <= fill_in;
         wq_left_ff <= wq_left_in;
         wq_idx_ff  <= wq_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_go) begin
         wq_npend_ff <= push_req.n_pend;
         wq_cur_ff   <= push_req.cur;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en)  mem[wr_addr] <= wr_data;
      if (pop_go) rd_data_ff   <= mem[head_ff];
   end

   assign wr_busy    = (wq_left_ff != 2'd0);
   assign pop_hit    = pop_go;
   assign fill_level = 7'(fill_in);
   assign rd_data    = rd_data_ff;

   ap_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(FIFO_DEPTH))
      else $error("FIFO fill count exceeds its depth");

   ap_no_read_of_unwritten: assert property (@(posedge clock) disable iff (reset)
      pop_go |-> !(wr_en && wr_addr == head_ff))
      else $error("pop reads an entry that is being written in the same cycle");

endmodule

/* sim/tb_arrow_key_escape_recognizer.sv */
// Self-checking testbench for the arrow-key escape recogniser and its character FIFO.
module tb_arrow_key_escape_recognizer;
   import akr_pkg::*;

   localparam int DEPTH = 64;
   localparam int RANDOM_PER_PHASE = 275;

   // One result transaction as the block should produce it.
   typedef struct {
      logic        decided;
      logic [2:0]  key;
      logic [31:0] pbytes;
      logic [2:0]  plen;
      logic        ovf;
      logic [6:0]  fill;
   } outcome_type;

   // Shadow copy of the recogniser and its FIFO. Every accepted request transaction
   // is applied here and the outcome it should give is queued; every result
   // transaction is then matched against the oldest queued outcome.
   class key_fifo_shadow;
      logic [3:0]  cand_mask;
      logic [7:0]  held [3];
      int unsigned held_cnt;
      entry_type   store [DEPTH];
      int unsigned head;
      int unsigned fill;
      outcome_type awaited_results [$];
      int          fault_count;

      function new();
         cand_mask = 4'hF;
         held_cnt = 0;
         head = 0;
         fill = 0;
         fault_count = 0;
      endfunction

      function void restart();
         cand_mask = 4'hF;
         held_cnt = 0;
      endfunction

      function void put(entry_type e);
         store[(head + fill) % DEPTH] = e;
         fill++;
      endfunction

      // Flushes the held bytes, and the current character if there is one, as text.
      // Either everything fits or nothing is written.
      function bit flush_text(bit with_cur, entry_type cur);
         entry_type e;
         int unsigned n;
         n = held_cnt + (with_cur ? 1 : 0);
         if (fill + n > DEPTH) return 1'b0;
         for (int i = 0; i < held_cnt; i++) begin
            e.len = LEN_SINGLE;
            e.bytes = {24'h0, held[i]};
            put(e);
         end
         if (with_cur) put(cur);
         return 1'b1;
      endfunction

      function void apply_request(logic act, logic [31:0] bytes, logic [2:0] len);
         outcome_type o;
         entry_type   cur;
         logic [3:0]  narrowed;
         logic [7:0]  b;
         logic [7:0]  want;
         int unsigned c;
         o.decided = 1'b0;
         o.key = KEY_NONE;
         o.pbytes = '0;
         o.plen = '0;
         o.ovf = 1'b0;
         if (act == ACT_POP) begin
            if (fill > 0) begin
               o.pbytes = store[head].bytes;
               o.plen = store[head].len;
               head = (head + 1) % DEPTH;
               fill--;
            end
         end else if (len != LEN_SINGLE) begin
            // A timeout or a multi-byte character ends the attempt.
            cur.len = len;
            cur.bytes = bytes;
            o.decided = 1'b1;
            if (held_cnt == 3 && cand_mask != 4'h0) begin
               c = 0;
               while (c < 3 && !cand_mask[c]) c++;
               o.key = KEY_UP + 3'(c);
               if (len != LEN_TIMEOUT) begin
                  if (fill + 1 > DEPTH) o.ovf = 1'b1;
                  else put(cur);
               end
            end else if (!flush_text(len != LEN_TIMEOUT, cur)) begin
               o.ovf = 1'b1;
            end
            restart();
         end else begin
            b = bytes[7:0];
            narrowed = 4'h0;
            // A NUL byte never matches, and nothing matches beyond the third byte.
            if (held_cnt < 3 && b != 8'h00) begin
               for (c = 0; c < 4; c++) begin
                  if (held_cnt == 0) want = ESC_BYTE;
                  else if (held_cnt == 1) want = BRACKET_BYTE;
                  else want = FINAL_BASE + 8'(c);
                  if (cand_mask[c] && want == b) narrowed[c] = 1'b1;
               end
            end
            if (narrowed == 4'h0) begin
               o.decided = 1'b1;
               cur.len = LEN_SINGLE;
               cur.bytes = {24'h0, b};
               if (!flush_text(1'b1, cur)) o.ovf = 1'b1;
               restart();
            end else begin
               cand_mask = narrowed;
               held[held_cnt] = b;
               held_cnt++;
            end
         end
         o.fill = fill[6:0];
         awaited_results.push_back(o);
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fault_count++;
         end
      endfunction

      function void match_result(logic decided, logic [2:0] key, logic [31:0] pbytes,
                                 logic [2:0] plen, logic ovf, logic [6:0] fill_seen);
         outcome_type o;
         if (awaited_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual key %0d fill %0d",
                     $time, key, fill_seen);
            fault_count++;
            return;
         end
         o = awaited_results.pop_front();
         check_field("decided", 32'(o.decided), 32'(decided));
         check_field("key_code", 32'(o.key), 32'(key));
         check_field("popped_bytes", o.pbytes, pbytes);
         check_field("popped_length", 32'(o.plen), 32'(plen));
         check_field("overflow", 32'(o.ovf), 32'(ovf));
         check_field("fill_level", 32'(o.fill), 32'(fill_seen));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_action = ACT_CHAR;
   logic [31:0] req_char_bytes = '0;
   logic [2:0]  req_char_length = LEN_TIMEOUT;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_decided;
   logic [2:0]  rsp_key_code;
   logic [31:0] rsp_popped_bytes;
   logic [2:0]  rsp_popped_length;
   logic        rsp_overflow;
   logic [6:0]  rsp_fill_level;

   key_fifo_shadow shadow = new();

   // Percentages of cycles in which the sender idles and the receiver stalls, and the
   // chance of a pop transaction ahead of each character event.
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int pop_pct = 20;
   int items_sent = 0;

   arrow_key_escape_recognizer #(.FIFO_DEPTH(DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_char_bytes(req_char_bytes),
      .req_char_length(req_char_length),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_decided(rsp_decided),
      .rsp_key_code(rsp_key_code),
      .rsp_popped_bytes(rsp_popped_bytes),
      .rsp_popped_length(rsp_popped_length),
      .rsp_overflow(rsp_overflow),
      .rsp_fill_level(rsp_fill_level)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The result side. Signals are read in the active region of the edge, so they hold
   // the values from before the edge; rsp_ready is then redrawn for the next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         shadow.match_result(rsp_decided, rsp_key_code, rsp_popped_bytes,
                             rsp_popped_length, rsp_overflow, rsp_fill_level);
      rsp_ready <= reset ? 1'b0 : ($urandom_range(99) >= rsp_stall_pct);
   end

   // Offers one request transaction, after a random idle stretch, and holds it until
   // it is taken. The shadow model sees it at the edge at which it was accepted.
   task automatic send_item(input logic act, input logic [31:0] bytes, input logic [2:0] len);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_char_bytes <= bytes;
      req_char_length <= len;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      shadow.apply_request(act, bytes, len);
      items_sent++;
   endtask

   // A character event, possibly preceded by pops whose payload fields are random.
   task automatic emit_char(input logic [31:0] bytes, input logic [2:0] len);
      while ($urandom_range(99) < pop_pct)
         send_item(ACT_POP, $urandom, 3'($urandom_range(7)));
      send_item(ACT_CHAR, bytes, len);
   endtask

   // A single byte with random bits above it; the block must ignore those bits.
   function automatic logic [31:0] noisy(input logic [7:0] b);
      logic [31:0] r;
      r = $urandom;
      return {r[31:8], b};
   endfunction

   // Either a timeout or a multi-byte character of length two to seven.
   task automatic send_terminator();
      if ($urandom_range(1) == 1) emit_char($urandom, LEN_TIMEOUT);
      else emit_char($urandom, 3'($urandom_range(2, 7)));
   endtask

   // Mostly complete cursor sequences, otherwise broken ones or plain noise.
   task automatic send_random_unit();
      logic [7:0] seq [3];
      logic [7:0] near;
      int kind;
      int reach;
      kind = $urandom_range(99);
      seq[0] = ESC_BYTE;
      seq[1] = BRACKET_BYTE;
      seq[2] = FINAL_BASE + 8'($urandom_range(3));
      if (kind < 60) begin
         for (int i = 0; i < 3; i++) emit_char(noisy(seq[i]), LEN_SINGLE);
         send_terminator();
      end else if (kind < 80) begin
         reach = $urandom_range(1, 3);
         for (int i = 0; i < reach; i++) emit_char(noisy(seq[i]), LEN_SINGLE);
         near = ($urandom_range(1) == 1) ? FINAL_BASE + 8'($urandom_range(4, 7))
                                         : seq[$urandom_range(2)];
         case ($urandom_range(3))
            0: emit_char($urandom, LEN_SINGLE);
            1: emit_char(noisy(8'h00), LEN_SINGLE);
            2: emit_char(noisy(near), LEN_SINGLE);
            default: send_terminator();
         endcase
      end else begin
         emit_char($urandom, 3'($urandom_range(7)));
      end
   endtask

   // Holds the sender off until every outstanding result transaction has arrived.
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (shadow.awaited_results.size() != 0) @(posedge clock);
   endtask

   initial begin
      int random_base;
      int block_left;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: no idling and no pops in between.
      pop_pct = 0;
      send_item(ACT_POP, 32'hFFFF_FFFF, 3'd7);               // pop from an empty FIFO
      send_item(ACT_CHAR, 32'h0, LEN_TIMEOUT);               // lone timeout, nothing stored
      send_item(ACT_CHAR, 32'hFFFF_FF00 | ESC_BYTE, LEN_SINGLE);
      send_item(ACT_CHAR, {24'h0, BRACKET_BYTE}, LEN_SINGLE);
      send_item(ACT_CHAR, {24'h0, FINAL_BASE}, LEN_SINGLE);
      send_item(ACT_CHAR, 32'hFFFF_FFFF, LEN_TIMEOUT);       // up, timeout is not stored
      send_item(ACT_CHAR, {24'h0, ESC_BYTE}, LEN_SINGLE);
      send_item(ACT_CHAR, {24'h0, BRACKET_BYTE}, LEN_SINGLE);
      send_item(ACT_CHAR, {24'h0, FINAL_BASE + 8'd1}, LEN_SINGLE);
      send_item(ACT_CHAR, 32'hFFFF_FFFF, 3'd2);              // down, character stored
      send_item(ACT_CHAR, {24'h0, ESC_BYTE}, LEN_SINGLE);
      send_item(ACT_CHAR, {24'h0, BRACKET_BYTE}, LEN_SINGLE);
      send_item(ACT_CHAR, {24'h0, FINAL_BASE + 8'd3}, LEN_SINGLE);
      send_item(ACT_CHAR, 32'h8765_4321, 3'd7);              // left, odd length stored
      send_item(ACT_CHAR, {24'h0, ESC_BYTE}, LEN_SINGLE);
      send_item(ACT_CHAR, 32'hABCD_EF00, LEN_SINGLE);        // NUL never matches
      send_item(ACT_CHAR, {24'h0, ESC_BYTE}, LEN_SINGLE);
      send_item(ACT_CHAR, {24'h0, BRACKET_BYTE}, LEN_SINGLE);
      send_item(ACT_CHAR, {24'h0, FINAL_BASE + 8'd2}, LEN_SINGLE);
      send_item(ACT_CHAR, {24'h0, "x"}, LEN_SINGLE);         // fourth byte: all four as text
      send_item(ACT_CHAR, {24'h0, ESC_BYTE}, LEN_SINGLE);
      send_item(ACT_CHAR, {24'h0, BRACKET_BYTE}, LEN_SINGLE);
      send_item(ACT_CHAR, 32'h0000_00E2, 3'd5);              // broken by a long character
      send_item(ACT_CHAR, 32'hF09F_98FF, 3'd4);
      send_item(ACT_POP, 32'h0, LEN_TIMEOUT);

      // Random part in four idling phases. The pop rate changes every 40 random units
      // so that the FIFO both fills to overflow and runs empty.
      random_base = items_sent;
      block_left = 0;
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 86;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 86;
            end
            default: begin
               send_idle_pct = 18;
               rsp_stall_pct = 18;
            end
         endcase
         pause_until_drained();
         while (items_sent < random_base + (ph + 1) * RANDOM_PER_PHASE) begin
            if (block_left == 0) begin
               case ($urandom_range(2))
                  0: pop_pct = 3;
                  1: pop_pct = 30;
                  default: pop_pct = 60;
               endcase
               block_left = 40;
            end
            send_random_unit();
            block_left--;
         end
      end

      pause_until_drained();
      repeat (8) @(posedge clock);
      if (shadow.fault_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Far beyond the slowest correct run.
   initial begin
      #5000000;
      $display("Verification failed");
      $finish;
   end

endmodule

/* arrow_key_escape_recognizer.f */
rtl/akr_pkg.sv
rtl/akr_recog.sv
rtl/akr_fifo.sv
rtl/arrow_key_escape_recognizer.sv
sim/tb_arrow_key_escape_recognizer.sv
